// ----- rtl/swm_pkg.sv -----
// ============================================================================
// swm_pkg: shared definitions for the sliding window median filter
// Types, widths, register map and state encoding used by the cell chain,
// the arrival RAM and the top level.
// ============================================================================
package swm_pkg;

    localparam int DATA_W         = 32;  // sample width
    localparam int OUT_W          = 33;  // twice the median, one fraction bit
    localparam int CFG_W          = 7;   // window_size register width
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 2;
    localparam int WINDOW_MAX_DEF = 64;

    localparam logic [APB_AW-1:0] REG_ADDR_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_W-1:0]  WINDOW_SIZE_RESET    = 7'd1;

    // Operation broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic                     clr;
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] key;
    } swm_cell_op_t;

    // What a cell shows to its two neighbors.
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     vld;
        logic                     gt;
    } swm_link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL,
        ST_INS,
        ST_MED_LO,
        ST_MED_HI
    } swm_state_t;

endpackage

// ----- rtl/sliding_window_median_core.sv -----
// ============================================================================
// sliding_window_median_core: streaming median over a sliding window
// Keeps the newest window_size samples in a circular RAM in arrival order
// and as an ascending chain of cells, and reports twice their median.
// ============================================================================
//
// Usage:
//   Samples enter on the input channel (in_valid / in_ready, fields sample and first).
//   Each item that leaves the window holding exactly window_size samples produces one
//   item on the output channel (out_valid / out_ready, field median_times_two), which
//   is twice the median: for an even window it is the sum of the two middle values.
//   Setting first empties the window before the sample enters. window_size is written
//   over the APB port at byte address 0 while the block is idle; zero acts as 1 and
//   values above WINDOW_MAX act as WINDOW_MAX.
// Sequencing:
//   Each item passes the accept, a read and a delete for every old sample that leaves
//   the window, the insert and, when a median is produced, the lower and upper pick.
//   No new item is taken before the block is back in idle. The pace is set by the
//   single arrival RAM read port and by the one insert or delete per cycle of the chain.
// Reset and stall:
//   Reset empties the window and sets window_size to 1. A finished median waits in the
//   output register; the next item is accepted meanwhile and processed up to its own
//   median, which waits until the register frees.
//
module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample,
    input  logic                     first,
    // median channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  median_times_two,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // ------------------------------------------------------------------
    // Configuration register. Misaligned addresses hit no register.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] window_size_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_ADDR_WINDOW_SIZE);
    assign prdata = (paddr == REG_ADDR_WINDOW_SIZE)
                  ? {{(APB_DW-CFG_W){1'b0}}, window_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            window_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    // The window actually used, clamped to 1..WINDOW_MAX.
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] w_eff;

    assign cfg_ext = CMP_W'(window_size_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(WINDOW_MAX))
        begin
            w_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CNT_W'(cfg_ext);
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    swm_state_t               state_reg;
    swm_state_t               state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [CNT_W-1:0]         w_eff_reg;
    logic [CNT_W-1:0]         w_eff_next;
    logic [PTR_W-1:0]         wp_reg;
    logic [PTR_W-1:0]         wp_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [OUT_W-1:0]  median_reg;

    logic                     in_fire;
    logic                     out_load;
    logic                     ram_we;
    logic                     ram_re;
    logic [PTR_W-1:0]         ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;
    swm_cell_op_t             op;

    // Oldest held sample sits cnt_reg places behind the write pointer.
    logic [CNT_W:0]           wp_ext;
    logic [CNT_W:0]           cnt_ext;
    logic [CNT_W:0]           old_addr;

    assign wp_ext  = (CNT_W+1)'(wp_reg);
    assign cnt_ext = (CNT_W+1)'(cnt_reg);

    always_comb
    begin
        if (wp_ext >= cnt_ext)
        begin
            old_addr = wp_ext - cnt_ext;
        end
        else
        begin
            old_addr = wp_ext + (CNT_W+1)'(WINDOW_MAX) - cnt_ext;
        end
    end

    assign ram_raddr = old_addr[PTR_W-1:0];
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        w_eff_next = w_eff_reg;
        wp_next    = wp_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        op.clr     = 1'b0;
        op.ins     = 1'b0;
        op.del     = 1'b0;
        op.key     = (state_reg == ST_DEL) ? ram_rdata : x_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    w_eff_next = w_eff;
                    if (first)
                    begin
                        op.clr   = 1'b1;
                        cnt_next = '0;
                    end
                    state_next = ST_DEL_RD;
                end
            end
            ST_DEL_RD:
            begin
                // Drop old samples until one place is left for the new one.
                if (cnt_reg >= w_eff_reg)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_DEL;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end
            ST_DEL:
            begin
                op.del     = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = ST_DEL_RD;
            end
            ST_INS:
            begin
                op.ins   = 1'b1;
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (wp_reg == PTR_W'(WINDOW_MAX - 1))
                begin
                    wp_next = '0;
                end
                else
                begin
                    wp_next = wp_reg + PTR_W'(1);
                end
                if (cnt_next == w_eff_reg)
                begin
                    state_next = ST_MED_LO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MED_LO:
            begin
                state_next = ST_MED_HI;
            end
            ST_MED_HI:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            w_eff_reg     <= CNT_W'(1);
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            w_eff_reg     <= w_eff_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Arrival order memory
    // ------------------------------------------------------------------
    swm_ram #(
        .DEPTH (WINDOW_MAX),
        .AW    (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (x_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sorted cell chain, smallest value in cell 0
    // ------------------------------------------------------------------
    swm_link_t                link [WINDOW_MAX];
    logic signed [DATA_W-1:0] cell_val [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]    cell_vld;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_link_t left_in;
        swm_link_t right_in;

        if (i == 0)
        begin : g_left_edge
            assign left_in = '{val: '0, vld: 1'b1, gt: 1'b0};
        end
        else
        begin : g_left
            assign left_in = link[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_right_edge
            assign right_in = '{val: '0, vld: 1'b0, gt: 1'b1};
        end
        else
        begin : g_right
            assign right_in = link[i+1];
        end

        swm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (op),
            .left  (left_in),
            .right (right_in),
            .link  (link[i])
        );

        assign cell_val[i] = link[i].val;
        assign cell_vld[i] = link[i].vld;
    end

    // ------------------------------------------------------------------
    // Median pick: lower middle first, then upper middle and the sum.
    // For an odd window both picks land on the same cell.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]         lo_idx;
    logic [CNT_W-1:0]         hi_idx;
    logic [CNT_W-1:0]         sel_idx;
    logic signed [DATA_W-1:0] sel_val;

    assign lo_idx  = (w_eff_reg - CNT_W'(1)) >> 1;
    assign hi_idx  = w_eff_reg >> 1;
    assign sel_idx = (state_reg == ST_MED_LO) ? lo_idx : hi_idx;
    assign sel_val = cell_val[sel_idx[PTR_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg <= sample;
        end
        if (state_reg == ST_MED_LO)
        begin
            lo_reg <= sel_val;
        end
        if (out_load)
        begin
            median_reg <= {lo_reg[DATA_W-1], lo_reg} + {sel_val[DATA_W-1], sel_val};
        end
    end

    assign out_valid        = out_valid_reg;
    assign median_times_two = median_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_vld) == 32'(cnt_reg))
        else $error("fill count disagrees with the valid cells of the chain");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= w_eff_reg || state_reg == ST_DEL_RD || state_reg == ST_DEL)
        else $error("fill count above the window outside the delete phase");

    a_median_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (cnt_reg == w_eff_reg))
        else $error("median taken from a window that is not full");

    for (genvar k = 0; k + 1 < WINDOW_MAX; k++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            cell_vld[k+1] |-> (cell_vld[k] && (cell_val[k] <= cell_val[k+1])))
            else $error("cell chain out of ascending order");
    end

endmodule

// ----- rtl/swm_cell.sv -----
// ============================================================================
// swm_cell: one cell of the sorted value chain
// Holds one value of the ascending multiset and shifts it toward or away
// from its neighbors on an insert or a delete.
// ============================================================================
module swm_cell
    import swm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  swm_cell_op_t op,
    input  swm_link_t    left,
    input  swm_link_t    right,
    output swm_link_t    link
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     vld_reg;
    logic                     vld_next;
    logic                     gt;
    logic                     ge;

    // An empty cell behaves as if it held plus infinity.
    assign gt = !vld_reg || (val_reg > op.key);
    assign ge = !vld_reg || (val_reg >= op.key);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (op.clr)
        begin
            vld_next = 1'b0;
        end
        else if (op.ins)
        begin
            if (left.gt)
            begin
                val_next = left.val;
                vld_next = left.vld;
            end
            else if (gt)
            begin
                val_next = op.key;
                vld_next = 1'b1;
            end
        end
        else if (op.del)
        begin
            // The first cell at or above the key holds the value to drop.
            if (ge)
            begin
                val_next = right.val;
                vld_next = right.vld;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val = val_reg;
    assign link.vld = vld_reg;
    assign link.gt  = gt;

endmodule

// ----- rtl/swm_ram.sv -----
// ============================================================================
// swm_ram: arrival order sample memory
// Simple dual port RAM, one write and one registered read per cycle.
// ============================================================================
module swm_ram
    import swm_pkg::*;
#(
    parameter int DEPTH = WINDOW_MAX_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- verif/tb_sliding_window_median_core.sv -----
// ============================================================================
// tb_sliding_window_median_core: self-checking bench for the median filter
// Streams signed samples through the core and changes window_size over APB
// between phases. A local window tracker computes twice the median of each
// full window, and every median item the core delivers is checked against it.
// ============================================================================
module tb_sliding_window_median_core
    import swm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 10;
    localparam int WIN_MAX       = WINDOW_MAX_DEF;
    // Worst case inside the core is a shrink from a full window of WIN_MAX
    // down to one, which drops every held sample.
    localparam int SETTLE_CYCLES = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 600;

    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    // One sample waiting to be offered on the input channel.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     restart;
    } sample_item_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample    = '0;
    logic                     first     = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [OUT_W-1:0]  median_times_two;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_AW-1:0]        paddr     = REG_ADDR_WINDOW_SIZE;
    logic [APB_DW-1:0]        pwdata    = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    // Samples not yet offered, and medians the core still owes us.
    sample_item_t            pending_samples[$];
    logic signed [OUT_W-1:0] expected_medians[$];

    // Local copy of the filter state: newest sample at index 0.
    logic signed [DATA_W-1:0] recent_samples[WIN_MAX];
    int unsigned              held_count = 0;
    logic [CFG_W-1:0]         window_cfg = WINDOW_SIZE_RESET;

    logic        in_fire = 1'b0;     // an input item was taken at the last rising edge
    logic        calm    = 1'b0;     // when set, neither side idles at random
    int unsigned quiet_cycles = 0;
    int unsigned errors       = 0;

    sliding_window_median_core #(.WINDOW_MAX(WIN_MAX)) uut (.*);

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Window tracker. Called once for every accepted input item. The window
    // register is clamped the same way the core does it: zero means one and
    // anything above WIN_MAX means WIN_MAX. Because the held count is clipped
    // to the current window, a shrink produces a median on the very next
    // item, while a grow has to refill before the next median shows up.
    // ------------------------------------------------------------------------
    task automatic track_sample(input logic signed [DATA_W-1:0] value,
                                input logic restart);
        int unsigned              win;
        int                       j;
        logic signed [DATA_W-1:0] ordered[WIN_MAX];
        logic signed [DATA_W-1:0] cur;
        logic signed [OUT_W-1:0]  lo;
        logic signed [OUT_W-1:0]  hi;
        win = (window_cfg == 0) ? 1 : (window_cfg > WIN_MAX) ? WIN_MAX : window_cfg;
        if (restart)
            held_count = 0;
        for (int i = WIN_MAX - 1; i > 0; i--)
            recent_samples[i] = recent_samples[i - 1];
        recent_samples[0] = value;
        held_count++;
        if (held_count > win)
            held_count = win;
        if (held_count == win)
        begin
            // Insertion sort of the held samples, ascending.
            for (int i = 0; i < win; i++)
            begin
                cur = recent_samples[i];
                j = i;
                while (j > 0 && ordered[j - 1] > cur)
                begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = cur;
            end
            if (win % 2)
                expected_medians.insert(expected_medians.size(),
                                        {ordered[win / 2], 1'b0});
            else
            begin
                // Sign extension to OUT_W keeps the sum from overflowing.
                lo = ordered[win / 2 - 1];
                hi = ordered[win / 2];
                expected_medians.insert(expected_medians.size(), lo + hi);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver and output receiver. Both update at the falling edge so
    // the core sees stable inputs at the rising edge. An item stays on the
    // bus until it is taken; after that the next one is offered, or the
    // channel idles with a chance of 7 in 100 unless calm is set.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive
        sample_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 7))
            begin
                nxt = pending_samples.pop_front();
                sample   <= nxt.value;
                first    <= nxt.restart;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && (calm || $urandom_range(99) >= 7);
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every delivered median against the oldest expectation,
    // feeds accepted samples to the tracker, and runs the watchdog. Output
    // is handled before input, since a median can never belong to the item
    // that is accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic signed [OUT_W-1:0] want;
        if (!rst_n)
        begin
            in_fire      <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    errors++;
                    $error("median_times_two: expected nothing, actual %0d",
                           median_times_two);
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (median_times_two !== want)
                    begin
                        errors++;
                        $error("median_times_two: expected %0d, actual %0d",
                               want, median_times_two);
                    end
                end
            end
            if (in_valid && in_ready)
                track_sample(sample, first);
            // The watchdog only counts cycles in which neither channel moves.
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("tb_sliding_window_median_core: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every sample is in and every median is out, then give the
    // core time to finish any sample that produces no median.
    task automatic settle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of window_size: a setup cycle, then an access cycle that
    // completes at the rising edge where pready is high.
    task automatic set_window(input logic [CFG_W-1:0] size);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_WINDOW_SIZE;
        pwdata  <= APB_DW'(size);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        window_cfg = size;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_sample(input logic signed [DATA_W-1:0] value,
                                input logic restart);
        sample_item_t item;
        item.value   = value;
        item.restart = restart;
        pending_samples.insert(pending_samples.size(), item);
    endtask

    initial
    begin : stimulus
        int unsigned              total;
        int unsigned              win;
        int unsigned              n_items;
        logic [CFG_W-1:0]         size;
        logic signed [DATA_W-1:0] value;
        int unsigned              pick;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Window of one: each sample is its own median, extremes included.
        set_window(CFG_W'(1));
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(0, 1'b0);
        queue_sample(-1, 1'b0);

        // Window of two: the sum of the middle pair reaches its largest and smallest values.
        set_window(CFG_W'(2));
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);

        // Window of three, with a restart while the window is full.
        set_window(CFG_W'(3));
        queue_sample(10, 1'b1);
        queue_sample(-20, 1'b0);
        queue_sample(30, 1'b0);
        queue_sample(7, 1'b1);
        queue_sample(8, 1'b0);
        queue_sample(9, 1'b0);

        // Shrink while full: a median must come out on the next sample.
        set_window(CFG_W'(2));
        queue_sample(100, 1'b0);
        queue_sample(50, 1'b0);

        // Grow while full: the window refills before the next median.
        set_window(CFG_W'(4));
        queue_sample(1, 1'b0);
        queue_sample(2, 1'b0);

        // A zero window behaves as a window of one.
        set_window(CFG_W'(0));
        queue_sample(5, 1'b0);
        queue_sample(-5, 1'b0);

        // Sizes above WIN_MAX clamp to WIN_MAX; the fill continues below.
        set_window(CFG_W'(127));
        queue_sample(-3, 1'b0);
        queue_sample(3, 1'b0);

        // Random phases. The first two use the largest windows; after that
        // most windows are small so the filter stays fast and medians are
        // frequent. Samples mix full-range values, tiny values that give
        // lots of duplicates, and the two extremes.
        total = 0;
        for (int p = 0; total < RANDOM_ITEMS; p++)
        begin
            case (p)
                0: size = CFG_W'(64);
                1: size = CFG_W'(127);
                default:
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        size = CFG_W'(64);
                    else if (pick == 1)
                        size = '0;
                    else if (pick == 2)
                        size = CFG_W'($urandom_range(127, 17));
                    else
                        size = CFG_W'($urandom_range(16, 1));
                end
            endcase
            set_window(size);
            // A long stretch with no idling on either side.
            calm <= (p == 3 || p == 4);
            win = (size == 0) ? 1 : (size > WIN_MAX) ? WIN_MAX : size;
            n_items = (win <= 16) ? 45 : win + 25;
            for (int k = 0; k < n_items; k++)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                else if (pick <= 3)
                    value = $signed($urandom_range(8)) - 4;
                else
                    value = $urandom;
                queue_sample(value, ($urandom_range(99) < 3) ||
                                    (k == 0 && $urandom_range(1) == 1));
            end
            total += n_items;
        end

        settle();
        @(negedge clk);
        if (errors == 0)
            $display("tb_sliding_window_median_core: clean");
        else
            $display("tb_sliding_window_median_core: errors");
        $finish;
    end

endmodule

// ----- sliding_window_median_core.f -----
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_ram.sv
rtl/sliding_window_median_core.sv
verif/tb_sliding_window_median_core.sv
